@@ hw/rtl/egc_pkg.sv @@
// Shared types and constants for the Eulerian graph classifier.
// Used by egc_front, egc_back and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package egc_pkg;
	localparam int unsigned VertexW = 4;
	localparam int unsigned CountW  = 5;

	typedef enum logic [0:0] {
		REQ_ADD  = 1'b0,
		REQ_EVAL = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		VERDICT_NONE  = 2'd0,
		VERDICT_PATH  = 2'd1,
		VERDICT_CYCLE = 2'd2
	} verdict_t;

	typedef struct packed {
		req_t               req;
		logic [VertexW-1:0] a;
		logic [VertexW-1:0] b;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        verdict;
		logic              connected;
		logic [CountW-1:0] odd_vertices;
	} res_t;
endpackage
`default_nettype wire

@@ hw/rtl/eulerian_graph_classifier.sv @@
// Top level of the Eulerian graph classifier: command queue plus back end.
// Depends on egc_pkg, egc_front and egc_back.
`timescale 1ns / 1ps
`default_nettype none
// Edge items are taken into a two-entry queue and applied one per cycle by
// the back end while it is idle. An evaluate item walks the graph depth
// first, one stack pop and one discovered neighbor per cycle, then counts
// odd vertices one per cycle, and its result waits in an output register;
// edges keep loading behind it, but the next evaluate holds until it is popped.
module eulerian_graph_classifier #(
	parameter int unsigned MAX_VERTICES = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [4:0] cfg_wdata,
	input  wire logic       push,
	output logic            full,
	input  wire logic [0:0] req_type,
	input  wire logic [3:0] vertex_a,
	input  wire logic [3:0] vertex_b,
	output logic            empty,
	input  wire logic       pop,
	output logic [1:0]      verdict,
	output logic            connected,
	output logic [4:0]      odd_vertices
);
	logic [4:0]    vcount_q;
	egc_pkg::cmd_t cmd_in, cmd;
	egc_pkg::res_t res;
	logic          cmd_valid, cmd_take, res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 5'd16;
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	assign cmd_in.req = egc_pkg::req_t'(req_type);
	assign cmd_in.a   = vertex_a;
	assign cmd_in.b   = vertex_b;

	egc_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd_in(cmd_in),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_out(cmd)
	);

	egc_back #(.MaxVertices(MAX_VERTICES)) u_back (
		.clk(clk), .arst_n(arst_n), .vertex_count(vcount_q), .cmd_valid(cmd_valid),
		.cmd_take(cmd_take), .cmd(cmd), .res_valid(res_valid), .res_take(pop), .res(res)
	);

	assign empty        = !res_valid;
	assign verdict      = res.verdict;
	assign connected    = res.connected;
	assign odd_vertices = res.odd_vertices;
endmodule
`default_nettype wire

@@ hw/rtl/egc_front.sv @@
// Front end: accepts items into a short command queue.
// Depends on egc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module egc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire egc_pkg::cmd_t cmd_in,
	output logic               cmd_valid,
	input  wire logic          cmd_take,
	output egc_pkg::cmd_t      cmd_out
);
	egc_pkg::cmd_t slot_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;
	logic          do_push, do_pop;

	assign full      = cnt_q == 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd_out   = slot_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/egc_back.sv @@
// Back end: graph stores, edge insertion, depth-first walk and verdict.
// Depends on egc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module egc_back #(
	parameter int unsigned MaxVertices = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [4:0]    vertex_count,
	input  wire logic          cmd_valid,
	output logic               cmd_take,
	input  wire egc_pkg::cmd_t cmd,
	output logic               res_valid,
	input  wire logic          res_take,
	output egc_pkg::res_t      res
);
	localparam int unsigned IdxW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
	localparam int unsigned DepW = $clog2(MaxVertices + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_POP   = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_COUNT = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [MaxVertices-1:0] adj_q [MaxVertices];
	logic [MaxVertices-1:0] odd_q, has_q, vis_q, fresh_q, cnt_bits_q;
	logic [IdxW-1:0]        stk_q [MaxVertices];
	logic [DepW-1:0]        dep_q;
	logic [IdxW-1:0]        pick_idx;
	logic [4:0]             oddc_q;
	logic [4:0]             ncnt;
	logic [MaxVertices-1:0] mask, live, pick;
	logic [MaxVertices-1:0] bit_a, bit_b;
	logic [IdxW-1:0]        first, top;
	logic                   in_a, in_b;

	assign ncnt = ({27'd0, vertex_count} > MaxVertices) ? 5'(MaxVertices) : vertex_count;
	always_comb begin
		for (int i = 0; i < MaxVertices; i++) mask[i] = i < ncnt;
		live  = has_q & mask;
		first = '0;
		for (int i = MaxVertices - 1; i >= 0; i--) if (live[i]) first = IdxW'(i);
		pick = fresh_q & (~fresh_q + 1'b1);
	end
	assign in_a  = {1'b0, cmd.a} < ncnt;
	assign in_b  = {1'b0, cmd.b} < ncnt;
	assign bit_a = MaxVertices'(1) << cmd.a;
	assign bit_b = MaxVertices'(1) << cmd.b;
	assign top   = stk_q[IdxW'(dep_q - 1'b1)];
	assign cmd_take = state_q == ST_IDLE && cmd_valid
		&& (cmd.req == egc_pkg::REQ_ADD || !res_valid);

	always_comb begin
		pick_idx = '0;
		for (int i = MaxVertices - 1; i >= 0; i--) if (pick[i]) pick_idx = IdxW'(i);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_take && cmd.req == egc_pkg::REQ_EVAL) begin
			stk_q[0] <= first;
		end else if (state_q == ST_SCAN && fresh_q != '0 && dep_q < DepW'(MaxVertices)) begin
			stk_q[IdxW'(dep_q)] <= pick_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			for (int i = 0; i < MaxVertices; i++) adj_q[i] <= '0;
			odd_q      <= '0;
			has_q      <= '0;
			vis_q      <= '0;
			fresh_q    <= '0;
			cnt_bits_q <= '0;
			dep_q      <= '0;
			oddc_q     <= '0;
			res_valid  <= 1'b0;
			res        <= '0;
		end else begin
			if (res_valid && res_take) res_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						if (cmd.req == egc_pkg::REQ_ADD) begin
							if (in_a && in_b) begin
								adj_q[cmd.a] <= adj_q[cmd.a] | bit_b;
								if (cmd.a != cmd.b) begin
									adj_q[cmd.b] <= adj_q[cmd.b] | bit_a;
									odd_q <= odd_q ^ (bit_a | bit_b);
								end
								has_q <= has_q | bit_a | bit_b;
							end
						end else begin
							cnt_bits_q <= odd_q & mask;
							oddc_q     <= '0;
							if (live != '0) begin
								vis_q   <= live & (~live + 1'b1);
								dep_q   <= DepW'(1);
								state_q <= ST_POP;
							end else begin
								vis_q   <= '0;
								dep_q   <= '0;
								state_q <= ST_COUNT;
							end
						end
					end
				end
				ST_POP: begin
					if (dep_q == '0) begin
						state_q <= ST_COUNT;
					end else begin
						dep_q   <= dep_q - 1'b1;
						fresh_q <= adj_q[top] & mask & ~vis_q;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (fresh_q == '0) begin
						state_q <= ST_POP;
					end else begin
						vis_q   <= vis_q | pick;
						fresh_q <= fresh_q & ~pick;
						if (dep_q < DepW'(MaxVertices)) dep_q <= dep_q + 1'b1;
					end
				end
				ST_COUNT: begin
					if (cnt_bits_q != '0) begin
						oddc_q     <= oddc_q + 5'd1;
						cnt_bits_q <= cnt_bits_q & (cnt_bits_q - 1'b1);
					end else begin
						res.connected    <= (live & ~vis_q) == '0;
						res.odd_vertices <= oddc_q;
						res.verdict      <= ((live & ~vis_q) != '0 || oddc_q > 5'd2)
							? egc_pkg::VERDICT_NONE
							: (oddc_q != 5'd0) ? egc_pkg::VERDICT_PATH : egc_pkg::VERDICT_CYCLE;
						res_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/egc_checker.sv @@
// Port-level checks for the Eulerian graph classifier, bound to the top.
// Depends on eulerian_graph_classifier.
`timescale 1ns / 1ps
`default_nettype none
module egc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [1:0] verdict,
	input wire logic       connected,
	input wire logic [4:0] odd_vertices
);
	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> verdict != 2'd3) else $error("bad verdict");
	a_unconn: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !connected) |-> verdict == 2'd0) else $error("unconnected not zero");
	a_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && verdict == 2'd2) |-> odd_vertices == 5'd0) else $error("cycle with odd");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(verdict))) else $error("result lost");
endmodule
bind eulerian_graph_classifier egc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .verdict(verdict),
	.connected(connected), .odd_vertices(odd_vertices)
);
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for eulerian_graph_classifier: directed table plus random traffic.
// Predicts verdicts by graph model or table row and checks the result queue item by item.
// Depends on egc_pkg and the eulerian_graph_classifier RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	typedef struct {
		egc_pkg::req_t req;
		logic [3:0]    a;
		logic [3:0]    b;
		bit            typed;
		egc_pkg::res_t res;
	} row_t;

	localparam int unsigned STALL_LIMIT = 20000;
	localparam int unsigned SETTLE_CYCLES = 200;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [4:0] cfg_wdata;
	logic       push;
	logic       full;
	logic [0:0] req_type;
	logic [3:0] vertex_a;
	logic [3:0] vertex_b;
	logic       empty;
	logic       pop;
	logic [1:0] verdict;
	logic       connected;
	logic [4:0] odd_vertices;

	eulerian_graph_classifier u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.push(push), .full(full), .req_type(req_type), .vertex_a(vertex_a),
		.vertex_b(vertex_b), .empty(empty), .pop(pop), .verdict(verdict),
		.connected(connected), .odd_vertices(odd_vertices)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	logic [15:0]   graph_rows [16];
	logic [15:0]   parity_bits;
	logic [15:0]   edge_bits;
	logic [4:0]    live_vertices;
	egc_pkg::res_t verdicts_due [$];
	bit            typed_pending;
	egc_pkg::res_t typed_res;
	int unsigned   mismatches;
	int unsigned   adds_taken;
	int unsigned   evals_taken;
	int unsigned   verdicts_seen;
	int unsigned   idle_cycles;

	function automatic egc_pkg::res_t classify_graph();
		int unsigned n;
		logic [15:0] mask, live, odd, seen, fresh;
		logic [3:0]  pending [16];
		int          depth;
		int unsigned v, cnt;
		bit          joined;
		egc_pkg::res_t r;
		n = (live_vertices > 16) ? 16 : live_vertices;
		mask = (n == 16) ? 16'hFFFF : 16'((17'd1 << n) - 1);
		live = edge_bits & mask;
		odd = parity_bits & mask;
		seen = '0;
		joined = 1'b1;
		if (live != '0) begin
			for (v = 0; v < 16; v++)
				if (live[v]) break;
			seen[v] = 1'b1;
			pending[0] = 4'(v);
			depth = 1;
			while (depth > 0) begin
				depth--;
				fresh = graph_rows[pending[depth]] & mask & ~seen;
				for (int w = 0; w < 16; w++)
					if (fresh[w]) begin
						seen[w] = 1'b1;
						if (depth < 16) begin
							pending[depth] = 4'(w);
							depth++;
						end
					end
			end
			joined = ((live & ~seen) == '0);
		end
		cnt = $countones(odd);
		r.connected = joined;
		r.odd_vertices = 5'(cnt);
		if (!joined || cnt > 2) r.verdict = egc_pkg::VERDICT_NONE;
		else if (cnt != 0) r.verdict = egc_pkg::VERDICT_PATH;
		else r.verdict = egc_pkg::VERDICT_CYCLE;
		return r;
	endfunction

	function automatic void apply_edge(logic [3:0] a, logic [3:0] b);
		int unsigned n;
		n = (live_vertices > 16) ? 16 : live_vertices;
		if (a >= n || b >= n) return;
		graph_rows[a][b] = 1'b1;
		graph_rows[b][a] = 1'b1;
		edge_bits[a] = 1'b1;
		edge_bits[b] = 1'b1;
		if (a != b) begin
			parity_bits[a] = ~parity_bits[a];
			parity_bits[b] = ~parity_bits[b];
		end
	endfunction

	always @(posedge clk) begin
		egc_pkg::res_t want;
		egc_pkg::res_t got;
		if (arst_n) begin
			if (cfg_we) live_vertices = cfg_wdata;
			if (push && !full) begin
				if (req_type == egc_pkg::REQ_ADD) begin
					apply_edge(vertex_a, vertex_b);
					adds_taken++;
				end else begin
					want = classify_graph();
					if (typed_pending) want = typed_res;
					verdicts_due.insert(verdicts_due.size(), want);
					evals_taken++;
				end
			end
			if (pop && !empty) begin
				got.verdict = verdict;
				got.connected = connected;
				got.odd_vertices = odd_vertices;
				verdicts_seen++;
				if (verdicts_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected verdict item %p", got);
				end else begin
					want = verdicts_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: verdict item %0d expected %p got %p",
								verdicts_seen, want, got);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("ERROR: no progress for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int unsigned gap_length();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	task automatic send_item(egc_pkg::req_t req, logic [3:0] a, logic [3:0] b, bit typed,
		egc_pkg::res_t res);
		int unsigned gap;
		push = 1'b1;
		req_type = req;
		vertex_a = a;
		vertex_b = b;
		typed_pending = typed;
		typed_res = res;
		do @(posedge clk); while (full);
		@(negedge clk);
		gap = gap_length();
		if (gap > 0) begin
			push = 1'b0;
			typed_pending = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic settle_and_write(logic [4:0] value);
		push = 1'b0;
		typed_pending = 1'b0;
		while (verdicts_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		int unsigned hold;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (verdicts_seen == 30 && hold == 0) begin
				pop = 1'b0;
				hold = 1;
				repeat (400) @(negedge clk);
			end
			pop = 1'b1;
			do @(posedge clk); while (empty);
			@(negedge clk);
			if ($urandom_range(0, 2) != 0) begin
				pop = 1'b0;
				repeat (gap_length()) @(negedge clk);
			end
		end
	end

	initial begin
		row_t          plan [$];
		logic [4:0]    counts [$];
		egc_pkg::res_t none_res;
		int unsigned   pick;
		logic [3:0]    a;
		logic [3:0]    b;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		push = 1'b0;
		req_type = egc_pkg::REQ_ADD;
		vertex_a = '0;
		vertex_b = '0;
		typed_pending = 1'b0;
		typed_res = '0;
		none_res = '0;
		mismatches = 0;
		adds_taken = 0;
		evals_taken = 0;
		verdicts_seen = 0;
		idle_cycles = 0;
		parity_bits = '0;
		edge_bits = '0;
		live_vertices = 5'd16;
		foreach (graph_rows[i]) graph_rows[i] = '0;

		plan = '{
			'{egc_pkg::REQ_EVAL, 4'd0,  4'd0,  1, '{egc_pkg::VERDICT_CYCLE, 1'b1, 5'd0}},
			'{egc_pkg::REQ_ADD,  4'd0,  4'd15, 0, '{2'd0, 1'b0, 5'd0}},
			'{egc_pkg::REQ_EVAL, 4'd15, 4'd15, 1, '{egc_pkg::VERDICT_PATH, 1'b1, 5'd2}},
			'{egc_pkg::REQ_ADD,  4'd15, 4'd0,  0, '{2'd0, 1'b0, 5'd0}},
			'{egc_pkg::REQ_EVAL, 4'd0,  4'd0,  1, '{egc_pkg::VERDICT_CYCLE, 1'b1, 5'd0}},
			'{egc_pkg::REQ_ADD,  4'd3,  4'd3,  0, '{2'd0, 1'b0, 5'd0}},
			'{egc_pkg::REQ_EVAL, 4'd0,  4'd0,  1, '{egc_pkg::VERDICT_NONE, 1'b0, 5'd0}},
			'{egc_pkg::REQ_ADD,  4'd3,  4'd0,  0, '{2'd0, 1'b0, 5'd0}},
			'{egc_pkg::REQ_EVAL, 4'd0,  4'd0,  0, '{2'd0, 1'b0, 5'd0}},
			'{egc_pkg::REQ_ADD,  4'd15, 4'd15, 0, '{2'd0, 1'b0, 5'd0}},
			'{egc_pkg::REQ_ADD,  4'd1,  4'd2,  0, '{2'd0, 1'b0, 5'd0}},
			'{egc_pkg::REQ_ADD,  4'd2,  4'd4,  0, '{2'd0, 1'b0, 5'd0}},
			'{egc_pkg::REQ_ADD,  4'd4,  4'd1,  0, '{2'd0, 1'b0, 5'd0}},
			'{egc_pkg::REQ_EVAL, 4'd0,  4'd0,  0, '{2'd0, 1'b0, 5'd0}},
			'{egc_pkg::REQ_ADD,  4'd1,  4'd3,  0, '{2'd0, 1'b0, 5'd0}},
			'{egc_pkg::REQ_EVAL, 4'd0,  4'd0,  0, '{2'd0, 1'b0, 5'd0}},
			'{egc_pkg::REQ_ADD,  4'd5,  4'd6,  0, '{2'd0, 1'b0, 5'd0}},
			'{egc_pkg::REQ_ADD,  4'd6,  4'd4,  0, '{2'd0, 1'b0, 5'd0}},
			'{egc_pkg::REQ_ADD,  4'd7,  4'd8,  0, '{2'd0, 1'b0, 5'd0}},
			'{egc_pkg::REQ_ADD,  4'd8,  4'd5,  0, '{2'd0, 1'b0, 5'd0}},
			'{egc_pkg::REQ_EVAL, 4'd0,  4'd0,  0, '{2'd0, 1'b0, 5'd0}}
		};
		counts = '{5'd1, 5'd0, 5'd2, 5'd3, 5'd5, 5'd8, 5'd12, 5'd31, 5'd17, 5'd10, 5'd16};

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i])
			send_item(plan[i].req, plan[i].a, plan[i].b, plan[i].typed, plan[i].res);

		foreach (counts[p]) begin
			settle_and_write(counts[p]);
			for (int k = 0; k < 62; k++) begin
				pick = $urandom_range(0, 99);
				a = 4'($urandom_range(0, 15));
				b = 4'($urandom_range(0, 15));
				if (pick < 22) begin
					send_item(egc_pkg::REQ_EVAL, a, b, 1'b0, none_res);
				end else begin
					if (pick < 70 && counts[p] > 1 && counts[p] <= 16) begin
						a = 4'($urandom_range(0, counts[p] - 1));
						b = 4'($urandom_range(0, counts[p] - 1));
					end
					send_item(egc_pkg::REQ_ADD, a, b, 1'b0, none_res);
				end
			end
		end

		push = 1'b0;
		typed_pending = 1'b0;
		while (verdicts_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (verdicts_due.size() != 0) mismatches++;
		$display("Run covered %0d edge items and %0d evaluate items over %0d vertex counts,",
			adds_taken, evals_taken, counts.size() + 1);
		$display("with %0d verdicts compared and %0d mismatches.", verdicts_seen, mismatches);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

@@ eulerian_graph_classifier.f @@
hw/rtl/egc_pkg.sv
hw/rtl/egc_front.sv
hw/rtl/egc_back.sv
hw/rtl/eulerian_graph_classifier.sv
hw/rtl/egc_checker.sv
tb/tb.sv
